@@ design/lfsr_random_byte_generator_macros.svh @@
// ----------------------------------------------------------------------------
// LFSR random byte generator assertion macros
// Shared property shorthands for the checker of the random byte generator.
// ----------------------------------------------------------------------------
`ifndef LFSR_RANDOM_BYTE_GENERATOR_MACROS_SVH
`define LFSR_RANDOM_BYTE_GENERATOR_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define LRBG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define LRBG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/lrbg_pkg.sv @@
// ----------------------------------------------------------------------------
// LFSR random byte generator package
// Field widths, tap offsets, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lrbg_pkg;

   // Word field widths.
   localparam int SEED_BITS     = 64;
   localparam int COUNT_BITS    = 7;
   localparam int REQ_DATA_BITS = 72;
   localparam int BYTE_BITS     = 8;
   localparam int BIT_CNT_BITS  = 3;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int WARM_BITS     = 16;
   localparam logic [WARM_BITS-1:0] WARM_RESET = 16'd256;

   // Register indexes.
   typedef enum logic [0:0] {
      REG_WARMUP = 1'b0
   } reg_index_type;

   // Tap offsets below the top of the register.
   localparam int TAP_A_OFFSET = 56;
   localparam int TAP_B_OFFSET = 13;
   localparam int TAP_C_OFFSET = 10;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_WARM_PRE  = 4'b0010,
      ST_BYTES     = 4'b0100,
      ST_WARM_POST = 4'b1000
   } seq_state_type;

   // Controls from the sequencer to the shift register.
   typedef struct packed {
      logic load;
      logic tick;
   } lfsr_ctrl_type;

endpackage

@@ design/lrbg_lfsr.sv @@
// ----------------------------------------------------------------------------
// LFSR random byte generator shift register
// Fibonacci shift register that loads a seed or advances by one bit a cycle when ticked.
// ----------------------------------------------------------------------------
module lrbg_lfsr #(
   parameter int STATE_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrbg_pkg::lfsr_ctrl_type ctrl,
   input  logic [STATE_BITS-1:0]  seed,
   output logic                   feedback
);
   import lrbg_pkg::*;

   logic [STATE_BITS-1:0] state_ff;
   logic [STATE_BITS-1:0] state_in;

   // Feedback is the XOR of the bottom bit and three taps set by offsets below the top.
   assign feedback = state_ff[0] ^ state_ff[STATE_BITS-TAP_A_OFFSET]
                   ^ state_ff[STATE_BITS-TAP_B_OFFSET] ^ state_ff[STATE_BITS-TAP_C_OFFSET];

   // A load replaces the state; a tick shifts right with feedback at the top.
   always_comb begin
      state_in = state_ff;
      if (ctrl.load) begin
         state_in = seed;
      end else if (ctrl.tick) begin
         state_in = {feedback, state_ff[STATE_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= {{(STATE_BITS-1){1'b0}}, 1'b1};
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/lfsr_random_byte_generator.sv @@
// ----------------------------------------------------------------------------
// LFSR random byte generator
// Request-driven byte generator built on a Fibonacci shift register.
// ----------------------------------------------------------------------------
// Each request word carries a seed and a byte count. A nonzero seed replaces
// the register state. The register then advances warmup_clocks times with the
// bits thrown away, produces the requested bytes from eight feedback bits each
// (first bit in bit zero, tlast on the final byte), and advances warmup_clocks
// times again before the next request is taken. The register advances one bit
// per cycle in the warm-ups and the byte phase, but the last bit of a byte
// waits while the previous byte is still held at the output. A count of
// zero still runs both warm-ups; a count above MAX_BYTES is cut to MAX_BYTES.
// An all-zero state stays all zero.
// ----------------------------------------------------------------------------
module lfsr_random_byte_generator #(
   parameter int STATE_BITS = 64,
   parameter int MAX_BYTES  = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request: seed [63:0], byte_count [70:64], zero [71].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrbg_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // Response: byte_value [7:0].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lrbg_pkg::BYTE_BITS-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lrbg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lrbg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lrbg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import lrbg_pkg::*;

   localparam logic [COUNT_BITS-1:0]   MAX_COUNT = COUNT_BITS'(MAX_BYTES);
   localparam logic [BIT_CNT_BITS-1:0] BIT_LAST  = BIT_CNT_BITS'(BYTE_BITS - 1);

   seq_state_type           fsm_ff, fsm_in;
   logic [WARM_BITS-1:0]    warmup_ff;
   logic [WARM_BITS-1:0]    warm_left_ff, warm_left_in;
   logic [COUNT_BITS-1:0]   bytes_left_ff, bytes_left_in;
   logic [BIT_CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [BYTE_BITS-1:0]    byte_ff, byte_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;
   lfsr_ctrl_type           lfsr_ctrl;
   logic                    feedback;
   logic [STATE_BITS-1:0]   seed;
   logic [COUNT_BITS-1:0]   req_count;
   logic [COUNT_BITS-1:0]   count_sat;
   reg_index_type           csr_index;
   logic                    csr_write;

   // Request fields; only the low bits of the seed reach the register.
   assign seed      = req_tdata[STATE_BITS-1:0];
   assign req_count = req_tdata[SEED_BITS +: COUNT_BITS];
   assign count_sat = (req_count > MAX_COUNT) ? MAX_COUNT : req_count;

   lrbg_lfsr #(
      .STATE_BITS (STATE_BITS)
   ) u_lfsr (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lfsr_ctrl),
      .seed     (seed),
      .feedback (feedback)
   );

   // Configuration register access.
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == REG_WARMUP)
                     ? {{(CSR_DATA_BITS-WARM_BITS){1'b0}}, warmup_ff}
                     : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff <= WARM_RESET;
      end else if (csr_write && (csr_index == REG_WARMUP)) begin
         warmup_ff <= csr_pwdata[WARM_BITS-1:0];
      end
   end

   // Sequencer: warm-up, byte assembly, second warm-up.
   always_comb begin
      fsm_in        = fsm_ff;
      warm_left_in  = warm_left_ff;
      bytes_left_in = bytes_left_ff;
      bit_cnt_in    = bit_cnt_ff;
      byte_in       = byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      lfsr_ctrl     = '0;

      unique case (fsm_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lfsr_ctrl.load = (seed != '0);
               warm_left_in   = warmup_ff;
               bytes_left_in  = count_sat;
               bit_cnt_in     = '0;
               fsm_in         = ST_WARM_PRE;
            end
         end
         ST_WARM_PRE: begin
            if (warm_left_ff != '0) begin
               lfsr_ctrl.tick = 1'b1;
               warm_left_in   = warm_left_ff - 1'b1;
            end else if (bytes_left_ff == '0) begin
               warm_left_in = warmup_ff;
               fsm_in       = ST_WARM_POST;
            end else begin
               fsm_in = ST_BYTES;
            end
         end
         ST_BYTES: begin
            // The last bit of a byte waits while the output word is still held.
            if ((bit_cnt_ff != BIT_LAST) || !rsp_valid_ff || rsp_tready) begin
               lfsr_ctrl.tick = 1'b1;
               byte_in        = {feedback, byte_ff[BYTE_BITS-1:1]};
               bit_cnt_in     = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == BIT_LAST) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = byte_in;
                  rsp_last_in   = (bytes_left_ff == COUNT_BITS'(1));
                  bytes_left_in = bytes_left_ff - 1'b1;
                  if (bytes_left_ff == COUNT_BITS'(1)) begin
                     warm_left_in = warmup_ff;
                     fsm_in       = ST_WARM_POST;
                  end
               end
            end
         end
         ST_WARM_POST: begin
            if (warm_left_ff != '0) begin
               lfsr_ctrl.tick = 1'b1;
               warm_left_in   = warm_left_ff - 1'b1;
            end else begin
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and payload.
   always_ff @(posedge clock) begin
      warm_left_ff  <= warm_left_in;
      bytes_left_ff <= bytes_left_in;
      bit_cnt_ff    <= bit_cnt_in;
      byte_ff       <= byte_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (fsm_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ design/lrbg_checker.sv @@
// ----------------------------------------------------------------------------
// LFSR random byte generator checker
// Port-level properties of the random byte generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfsr_random_byte_generator_macros.svh"

module lrbg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [lrbg_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [lrbg_pkg::BYTE_BITS-1:0]      rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [lrbg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [lrbg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [lrbg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                                csr_pready
);
   import lrbg_pkg::*;

   logic req_accept;
   logic warm_write;

   assign req_accept = req_tvalid && req_tready && (req_tdata[REQ_DATA_BITS-1] == 1'b0
                     || req_tdata[REQ_DATA_BITS-1] == 1'b1);
   assign warm_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                     && (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WARMUP);

   // A held response word keeps its byte and its last flag.
   `LRBG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response word changed while stalled")

   // A request is worked on alone: the input closes right after acceptance.
   `LRBG_ASSERT_NEXT(a_req_busy, clock, reset, req_accept, !req_tready, "request input stayed open after acceptance")

   // A fresh response word only comes out of the byte phase of a request.
   `LRBG_ASSERT_SAME(a_rsp_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "response word appeared while idle")

   // The warm-up register reads back what was written.
   `LRBG_ASSERT_SAME(a_csr_readback, clock, reset, warm_write ##1 (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WARMUP), csr_prdata == {{(CSR_DATA_BITS-WARM_BITS){1'b0}}, $past(csr_pwdata[WARM_BITS-1:0])}, "warm-up register readback mismatch")

endmodule

bind lfsr_random_byte_generator lrbg_checker u_lrbg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tlast   (rsp_tlast),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
